>>> rtl/fra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants of the four-register integer executor.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int REG_W    = 32;
  localparam int NUM_REGS = 4;
  localparam int REG_AW   = 2;
  localparam int FUNC_W   = 3;

  // Restoring division produces one quotient bit per step.
  localparam int DIV_STEPS = REG_W;
  localparam int DIV_CNT_W = 5;

  // Operation codes. Code 7 has no meaning and behaves as a read out.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_IN  = 3'd0,
    FUNC_MOV = 3'd1,
    FUNC_ADD = 3'd2,
    FUNC_SUB = 3'd3,
    FUNC_MUL = 3'd4,
    FUNC_DIV = 3'd5,
    FUNC_OUT = 3'd6
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // request accepted: latch fields, read the register file
    logic exec;      // operands ready: compute, or set up the divider
    logic div_step;  // one restoring division step
    logic div_fix;   // apply the quotient sign
    logic finish;    // write back and load the output register
  } fra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_run;   // division with a nonzero divisor needs the iterative unit
  } fra_sts_t;

endpackage
`default_nettype wire

>>> rtl/fra_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fra_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module fra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output      logic [WIDTH-1:0]         rdata_a,
  output      logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

>>> rtl/fra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fra_ctrl
// Sequencer of the executor: handshakes, division step count, output valid.
// ----------------------------------------------------------------------------
module fra_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  input  wire fra_pkg::fra_sts_t sts,
  output      fra_pkg::fra_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_FIX    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t                          state, state_next;
  logic [fra_pkg::DIV_CNT_W-1:0]   cnt, cnt_next;
  logic                            slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cnt_next = '0;
        state_next = sts.div_run ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == fra_pkg::DIV_CNT_W'(fra_pkg::DIV_STEPS - 1)) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        // The result waits here until the output register is free.
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fra_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fra_dp
// Datapath: register file, ALU with multiplier, restoring divider, output.
// ----------------------------------------------------------------------------
module fra_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fra_pkg::fra_cmd_t             cmd,
  output      fra_pkg::fra_sts_t             sts,
  input  wire logic [fra_pkg::FUNC_W-1:0]    func,
  input  wire logic [fra_pkg::REG_AW-1:0]    dest_reg,
  input  wire logic [fra_pkg::REG_AW-1:0]    src_reg,
  input  wire logic signed [fra_pkg::REG_W-1:0] immediate,
  output      logic signed [fra_pkg::REG_W-1:0] reg_value,
  output      logic                          status
);

  localparam int W = fra_pkg::REG_W;

  fra_pkg::func_t                func_q;
  logic [fra_pkg::REG_AW-1:0]    dest_q;
  logic [W-1:0]                  imm_q;
  logic [fra_pkg::NUM_REGS-1:0]  vld;
  logic                          dv_vld, sv_vld;
  logic [W-1:0]                  ram_a, ram_b;
  logic [W-1:0]                  dv, sv;
  logic [W-1:0]                  prod;
  logic [W-1:0]                  exec_val;
  logic                          exec_st;
  logic [W-1:0]                  res;
  logic                          res_st;
  logic [W-1:0]                  quo, rem, dsr;
  logic                          neg;
  logic [W:0]                    rem_sh, trial;
  logic                          wr_en;

  // Entries never written since reset read as zero.
  fra_ram #(
    .WIDTH(W),
    .DEPTH(fra_pkg::NUM_REGS)
  ) u_regs (
    .clk     (clk),
    .we      (cmd.finish && wr_en),
    .waddr   (dest_q),
    .wdata   (res),
    .re      (cmd.capture),
    .raddr_a (dest_reg),
    .raddr_b (src_reg),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  assign dv   = dv_vld ? ram_a : '0;
  assign sv   = sv_vld ? ram_b : '0;
  assign prod = dv * sv;

  assign sts.div_run = (func_q == fra_pkg::FUNC_DIV) && (sv != '0);

  always_comb begin
    exec_val = dv;
    exec_st  = 1'b0;
    case (func_q)
      fra_pkg::FUNC_IN:  exec_val = imm_q;
      fra_pkg::FUNC_MOV: exec_val = sv;
      fra_pkg::FUNC_ADD: exec_val = dv + sv;
      fra_pkg::FUNC_SUB: exec_val = dv - sv;
      fra_pkg::FUNC_MUL: exec_val = prod;
      fra_pkg::FUNC_DIV: exec_st  = (sv == '0);
      default:           exec_val = dv;
    endcase
  end

  always_comb begin
    case (func_q)
      fra_pkg::FUNC_IN, fra_pkg::FUNC_MOV, fra_pkg::FUNC_ADD,
      fra_pkg::FUNC_SUB, fra_pkg::FUNC_MUL, fra_pkg::FUNC_DIV: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem, quo[W-1]};
  assign trial  = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.finish && wr_en) begin
      vld[dest_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= fra_pkg::func_t'(func);
      dest_q <= dest_reg;
      imm_q  <= immediate;
      dv_vld <= vld[dest_reg];
      sv_vld <= vld[src_reg];
    end
    if (cmd.exec) begin
      res    <= exec_val;
      res_st <= exec_st;
      quo    <= dv[W-1] ? (~dv + 1'b1) : dv;
      dsr    <= sv[W-1] ? (~sv + 1'b1) : sv;
      rem    <= '0;
      neg    <= dv[W-1] ^ sv[W-1];
    end
    if (cmd.div_step) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      res    <= neg ? (~quo + 1'b1) : quo;
      res_st <= 1'b0;
    end
    if (cmd.finish) begin
      reg_value <= res;
      status    <= res_st;
    end
  end

endmodule
`default_nettype wire

>>> rtl/four_register_alu_executor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_register_alu_executor
// Executes decoded instructions on four 32-bit signed registers A to D.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one request: func, dest_reg,
//   src_reg and immediate. The output channel (out_valid/out_ready) returns
//   one result per request: the destination register after the operation in
//   reg_value, and status, which is 1 only for a division by zero (the
//   destination then keeps its value).
//   Requests are handled one at a time. Load, copy, add, subtract, multiply
//   and read out pass from acceptance through an execute state to a finish
//   state that writes back and raises out_valid. Division adds the restoring
//   divider, which resolves one quotient bit per cycle for all 32 bits, and a
//   sign fix between operand read and write back; a division by zero skips both.
//   A finished result sits in the output register until taken; the next
//   request is already accepted meanwhile, and its result waits inside until
//   the output register frees up. Reset clears all four registers to zero
//   and empties the output register.
// ----------------------------------------------------------------------------
module four_register_alu_executor (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [2:0]         func,
  input  wire logic [1:0]         dest_reg,
  input  wire logic [1:0]         src_reg,
  input  wire logic signed [31:0] immediate,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [31:0] reg_value,
  output      logic               status
);

  fra_pkg::fra_cmd_t cmd;
  fra_pkg::fra_sts_t sts;

  fra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func      (func),
    .dest_reg  (dest_reg),
    .src_reg   (src_reg),
    .immediate (immediate),
    .reg_value (reg_value),
    .status    (status)
  );

endmodule
`default_nettype wire

>>> dv/four_register_alu_executor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_register_alu_executor_tb
// Drives decoded instructions into the four-register executor and checks each
// returned register value and status against a register-file predictor. The
// run starts with directed corner cases (extreme values, every operation,
// divide by zero, divide overflow, same source and destination, the unused
// operation code), then random requests under several idle and stall mixes
// and one long output hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------

typedef struct {
  logic [31:0] value;
  logic        status;
} alu_result_t;

class regfile_predictor;
  logic [31:0] regs [fra_pkg::NUM_REGS];
  alu_result_t expected_q [$];
  int          errors;

  function new();
    foreach (regs[i]) regs[i] = '0;
    errors = 0;
  endfunction

  // Signed division truncating toward zero; -2^31 / -1 wraps back to -2^31.
  function logic [31:0] quotient_toward_zero(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] q;
    mag_n = num[31] ? (32'd0 - num) : num;
    mag_d = den[31] ? (32'd0 - den) : den;
    q = mag_n / mag_d;
    return (num[31] ^ den[31]) ? (32'd0 - q) : q;
  endfunction

  function void note_request(logic [fra_pkg::FUNC_W-1:0] f,
                             logic [fra_pkg::REG_AW-1:0] d,
                             logic [fra_pkg::REG_AW-1:0] s, logic [31:0] imm);
    logic [31:0] dv;
    logic [31:0] sv;
    alu_result_t res;
    dv = regs[d];
    sv = regs[s];
    res.status = 1'b0;
    case (f)
      fra_pkg::FUNC_IN:  dv = imm;
      fra_pkg::FUNC_MOV: dv = sv;
      fra_pkg::FUNC_ADD: dv = dv + sv;
      fra_pkg::FUNC_SUB: dv = dv - sv;
      fra_pkg::FUNC_MUL: dv = dv * sv;
      fra_pkg::FUNC_DIV: begin
        if (sv == 32'd0) begin
          res.status = 1'b1;
        end else begin
          dv = quotient_toward_zero(dv, sv);
        end
      end
      default: ;
    endcase
    regs[d] = dv;
    res.value = dv;
    expected_q.push_back(res);
  endfunction

  function void check_result(logic [31:0] value, logic st);
    alu_result_t res;
    if (expected_q.size() == 0) begin
      $display("%0t: result with none expected: reg_value=%h status=%b", $time, value, st);
      errors++;
      return;
    end
    res = expected_q.pop_front();
    if (value !== res.value) begin
      $display("%0t: reg_value mismatch: expected %h, actual %h", $time, res.value, value);
      errors++;
    end
    if (st !== res.status) begin
      $display("%0t: status mismatch: expected %b, actual %b", $time, res.status, st);
      errors++;
    end
  endfunction
endclass

module four_register_alu_executor_tb;

  localparam logic [fra_pkg::FUNC_W-1:0] FUNC_UNUSED = 3'd7;
  localparam logic [fra_pkg::REG_AW-1:0] REG_A = 2'd0;
  localparam logic [fra_pkg::REG_AW-1:0] REG_B = 2'd1;
  localparam logic [fra_pkg::REG_AW-1:0] REG_C = 2'd2;
  localparam logic [fra_pkg::REG_AW-1:0] REG_D = 2'd3;
  localparam int PHASE_ITEMS  = 108;
  localparam int SQUEEZE_ITEMS = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         func = '0;
  logic [1:0]         dest_reg = '0;
  logic [1:0]         src_reg = '0;
  logic signed [31:0] immediate = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] reg_value;
  logic               status;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  regfile_predictor regfile_model = new();

  four_register_alu_executor DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .dest_reg  (dest_reg),
    .src_reg   (src_reg),
    .immediate (immediate),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .reg_value (reg_value),
    .status    (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check every accepted result, then decide the next ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      regfile_model.check_result(reg_value, status);
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input logic [fra_pkg::FUNC_W-1:0] f,
                              input logic [fra_pkg::REG_AW-1:0] d,
                              input logic [fra_pkg::REG_AW-1:0] s,
                              input logic [31:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    dest_reg <= d;
    src_reg <= s;
    immediate <= imm;
    do @(posedge clk); while (!in_ready);
    regfile_model.note_request(f, d, s, imm);
  endtask

  function automatic logic [31:0] pick_immediate();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      4, 5: return 32'($urandom_range(16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  // Loads are frequent so the registers keep a mix of zeros, small values and
  // extremes; small values make divide by zero and exact quotients common.
  task automatic send_random_request();
    logic [fra_pkg::FUNC_W-1:0] f;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) f = fra_pkg::FUNC_IN;
    else if (pick < 35) f = fra_pkg::FUNC_MOV;
    else if (pick < 47) f = fra_pkg::FUNC_ADD;
    else if (pick < 57) f = fra_pkg::FUNC_SUB;
    else if (pick < 67) f = fra_pkg::FUNC_MUL;
    else if (pick < 85) f = fra_pkg::FUNC_DIV;
    else if (pick < 95) f = fra_pkg::FUNC_OUT;
    else f = FUNC_UNUSED;
    send_request(f, 2'($urandom_range(3)), 2'($urandom_range(3)), pick_immediate());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(fra_pkg::FUNC_OUT, REG_A, REG_B, 32'h1234_5678);
    send_request(fra_pkg::FUNC_IN,  REG_A, REG_A, 32'h7FFF_FFFF);
    send_request(fra_pkg::FUNC_IN,  REG_B, REG_D, 32'h8000_0000);
    send_request(fra_pkg::FUNC_IN,  REG_C, REG_B, 32'hFFFF_FFFF);
    send_request(fra_pkg::FUNC_IN,  REG_D, REG_C, 32'h0000_0000);
    send_request(fra_pkg::FUNC_ADD, REG_A, REG_A, 32'hFFFF_FFFF);
    send_request(fra_pkg::FUNC_SUB, REG_B, REG_A, 32'h0);
    send_request(fra_pkg::FUNC_MUL, REG_C, REG_C, 32'h0);
    send_request(fra_pkg::FUNC_DIV, REG_A, REG_D, 32'h0);
    send_request(fra_pkg::FUNC_IN,  REG_D, REG_A, 32'hFFFF_FFFF);
    send_request(fra_pkg::FUNC_IN,  REG_B, REG_A, 32'h8000_0000);
    send_request(fra_pkg::FUNC_DIV, REG_B, REG_D, 32'h0);
    send_request(fra_pkg::FUNC_MOV, REG_C, REG_B, 32'hFFFF_FFFF);
    send_request(fra_pkg::FUNC_SUB, REG_C, REG_C, 32'h0);
    send_request(fra_pkg::FUNC_DIV, REG_D, REG_C, 32'h0);
    send_request(fra_pkg::FUNC_IN,  REG_A, REG_C, 32'hFFFF_FFF9);
    send_request(fra_pkg::FUNC_IN,  REG_D, REG_B, 32'h0000_0002);
    send_request(fra_pkg::FUNC_DIV, REG_A, REG_D, 32'h0);
    send_request(fra_pkg::FUNC_DIV, REG_D, REG_D, 32'h0);
    send_request(fra_pkg::FUNC_MUL, REG_A, REG_B, 32'h0);
    send_request(FUNC_UNUSED, REG_C, REG_A, 32'hA5A5_A5A5);
    send_request(fra_pkg::FUNC_IN,  REG_A, REG_D, 32'h5555_5555);
    send_request(fra_pkg::FUNC_IN,  REG_B, REG_C, 32'hAAAA_AAAA);
    send_request(fra_pkg::FUNC_MUL, REG_A, REG_B, 32'h0);
    send_request(fra_pkg::FUNC_DIV, REG_B, REG_A, 32'h0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 64; end
        default: begin send_idle_pct = 22; recv_stall_pct <= 22; end
      endcase
      repeat (PHASE_ITEMS) send_random_request();
    end

    // Hold the output back long enough that the block fills and stalls input.
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (SQUEEZE_ITEMS) send_random_request();

    in_valid <= 1'b0;
    while (regfile_model.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (regfile_model.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
